// ===== rtl/i2crm_pkg.sv =====
// Shared types and codes for the I2C register master.
`timescale 1ns / 1ps

package i2crm_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SDA_LOW   = 2'd1;
    localparam logic [1:0] STATUS_SDA_STUCK = 2'd2;
    localparam logic [1:0] STATUS_ADDR_NACK = 2'd3;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd7;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_last;
        logic       done_res;
        logic [1:0] status;
    } result_t;

endpackage

// ===== rtl/i2crm_seq.sv =====
// Bus sequencer: state registers and per-tick next-state logic.
`timescale 1ns / 1ps

module i2crm_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [1:0]          cmd,
    input  logic [6:0]          dev_addr,
    input  logic [7:0]          reg_addr,
    input  logic [7:0]          wr_data,
    input  logic [7:0]          rd_len,
    input  logic                sda_in,
    input  logic [7:0]          phase_ticks,
    output i2crm_pkg::result_t  result
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SA, ST_SB, ST_SC,
        ST_TXL, ST_TXD, ST_TXH,
        ST_WAL, ST_WAR, ST_WAH,
        ST_RXL, ST_RXH,
        ST_AKL, ST_AKD, ST_AKH, ST_AKE,
        ST_PA, ST_PB, ST_PC, ST_PD
    } step_t;

    typedef enum logic [1:0] {
        STAGE_ADDR_W, STAGE_REG, STAGE_DATA, STAGE_ADDR_R
    } stage_t;

    typedef struct packed {
        step_t      step;
        logic [7:0] timer;
        logic [3:0] bit_index;
        logic [7:0] shift_byte;
        logic [7:0] bytes_left;
        logic [6:0] device;
        logic [7:0] register;
        logic [7:0] value;
        logic       read_mode;
        logic       scl_level;
        logic       sda_level;
        stage_t     stage;
    } state_t;

    localparam state_t STATE_RESET = '{
        step:       ST_IDLE,
        timer:      8'd0,
        bit_index:  4'd0,
        shift_byte: 8'd0,
        bytes_left: 8'd0,
        device:     7'd0,
        register:   8'd0,
        value:      8'd0,
        read_mode:  1'b0,
        scl_level:  1'b1,
        sda_level:  1'b1,
        stage:      STAGE_ADDR_W
    };

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        step_t      ent;
        logic       do_enter;
        logic [7:0] timer_dec;
        logic [3:0] bit_inc;
        logic       first;

        state_next = state_reg;
        result     = '0;
        ent        = ST_IDLE;
        do_enter   = 1'b0;
        timer_dec  = (state_reg.timer != 8'd0) ? state_reg.timer - 8'd1 : 8'd0;
        bit_inc    = state_reg.bit_index + 4'd1;
        first      = (state_reg.stage == STAGE_ADDR_W);

        if (advance)
        begin
            if (state_reg.step == ST_IDLE)
            begin
                if (cmd == i2crm_pkg::CMD_WRITE || cmd == i2crm_pkg::CMD_READ)
                begin
                    state_next.device     = dev_addr;
                    state_next.register   = reg_addr;
                    state_next.value      = wr_data;
                    state_next.read_mode  = (cmd == i2crm_pkg::CMD_READ);
                    state_next.bytes_left = (cmd == i2crm_pkg::CMD_READ) ? rd_len : 8'd0;
                    state_next.stage      = STAGE_ADDR_W;
                    state_next.bit_index  = 4'd0;
                    state_next.shift_byte = {dev_addr, 1'b0};
                    ent      = ST_SA;
                    do_enter = 1'b1;
                end
            end
            else
            begin
                state_next.timer = timer_dec;
                if (timer_dec == 8'd0)
                begin
                    do_enter = 1'b1;
                    unique case (state_reg.step)
                        ST_SA:
                        begin
                            if (first && !sda_in)
                            begin
                                do_enter         = 1'b0;
                                state_next.step  = ST_IDLE;
                                result.done_res  = 1'b1;
                                result.status    = i2crm_pkg::STATUS_SDA_LOW;
                            end
                            else
                                ent = ST_SB;
                        end
                        ST_SB:
                        begin
                            if (first && sda_in)
                            begin
                                do_enter         = 1'b0;
                                state_next.step  = ST_IDLE;
                                result.done_res  = 1'b1;
                                result.status    = i2crm_pkg::STATUS_SDA_STUCK;
                            end
                            else
                                ent = ST_SC;
                        end
                        ST_SC:
                        begin
                            state_next.bit_index = 4'd0;
                            ent = ST_TXL;
                        end
                        ST_TXL: ent = ST_TXD;
                        ST_TXD: ent = ST_TXH;
                        ST_TXH:
                        begin
                            if (bit_inc[3])
                            begin
                                state_next.bit_index = 4'd0;
                                ent = ST_WAL;
                            end
                            else
                            begin
                                state_next.bit_index = bit_inc;
                                ent = ST_TXL;
                            end
                        end
                        ST_WAL: ent = ST_WAR;
                        ST_WAR: ent = ST_WAH;
                        ST_WAH:
                        begin
                            state_next.scl_level = 1'b0;
                            if (state_reg.stage == STAGE_ADDR_W)
                            begin
                                if (sda_in)
                                    ent = ST_PA;
                                else
                                begin
                                    state_next.stage      = STAGE_REG;
                                    state_next.shift_byte = state_reg.register;
                                    ent = ST_TXL;
                                end
                            end
                            else if (state_reg.stage == STAGE_REG)
                            begin
                                if (state_reg.read_mode)
                                begin
                                    state_next.stage      = STAGE_ADDR_R;
                                    state_next.shift_byte = {state_reg.device, 1'b1};
                                    ent = ST_SA;
                                end
                                else
                                begin
                                    state_next.stage      = STAGE_DATA;
                                    state_next.shift_byte = state_reg.value;
                                    ent = ST_TXL;
                                end
                            end
                            else if (state_reg.stage == STAGE_ADDR_R
                                     && state_reg.bytes_left != 8'd0)
                            begin
                                state_next.bit_index  = 4'd0;
                                state_next.shift_byte = 8'd0;
                                ent = ST_RXL;
                            end
                            else
                                ent = ST_PA;
                        end
                        ST_RXL: ent = ST_RXH;
                        ST_RXH:
                        begin
                            state_next.shift_byte = {state_reg.shift_byte[6:0], sda_in};
                            if (bit_inc[3])
                            begin
                                state_next.bit_index = 4'd0;
                                result.rd_data  = {state_reg.shift_byte[6:0], sda_in};
                                result.rd_valid = 1'b1;
                                result.rd_last  = (state_reg.bytes_left == 8'd1);
                                ent = ST_AKL;
                            end
                            else
                            begin
                                state_next.bit_index = bit_inc;
                                ent = ST_RXL;
                            end
                        end
                        ST_AKL: ent = ST_AKD;
                        ST_AKD: ent = ST_AKH;
                        ST_AKH: ent = ST_AKE;
                        ST_AKE:
                        begin
                            if (state_reg.bytes_left != 8'd0)
                                state_next.bytes_left = state_reg.bytes_left - 8'd1;
                            if (state_next.bytes_left == 8'd0)
                                ent = ST_PA;
                            else
                            begin
                                state_next.shift_byte = 8'd0;
                                ent = ST_RXL;
                            end
                        end
                        ST_PA: ent = ST_PB;
                        ST_PB: ent = ST_PC;
                        ST_PC: ent = ST_PD;
                        default:
                        begin
                            // stop complete (or unknown step): back to idle
                            do_enter         = 1'b0;
                            state_next.step  = ST_IDLE;
                            state_next.timer = 8'd0;
                            result.done_res  = 1'b1;
                            if (state_reg.step == ST_PD && first)
                                result.status = i2crm_pkg::STATUS_ADDR_NACK;
                            else
                                result.status = i2crm_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
        end

        if (do_enter)
        begin
            state_next.step = ent;
            unique case (ent)
                ST_SA:
                begin
                    state_next.sda_level = 1'b1;
                    state_next.scl_level = 1'b1;
                end
                ST_SB, ST_SC, ST_PB: state_next.sda_level = 1'b0;
                ST_TXL, ST_WAL, ST_AKL, ST_AKE, ST_PA: state_next.scl_level = 1'b0;
                ST_TXD:
                begin
                    state_next.sda_level  = state_next.shift_byte[7];
                    state_next.shift_byte = {state_next.shift_byte[6:0], 1'b0};
                end
                ST_TXH, ST_WAH, ST_RXH, ST_AKH, ST_PC: state_next.scl_level = 1'b1;
                ST_WAR, ST_PD: state_next.sda_level = 1'b1;
                ST_RXL:
                begin
                    state_next.sda_level = 1'b1;
                    state_next.scl_level = 1'b0;
                end
                // last received byte gets no acknowledge
                ST_AKD: state_next.sda_level = (state_next.bytes_left == 8'd1);
                default: ;
            endcase
            state_next.timer = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
        end

        result.scl_out  = state_next.scl_level;
        result.sda_out  = state_next.sda_level;
        result.busy_res = (state_next.step != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/i2c_register_master.sv =====
// I2C register master: handshake, phase length register and result register.
// A tick's result is registered into the output register when the tick is accepted.
// Throughput: one tick per cycle while the output is not stalled; the sequencer step
// logic sits between the state registers and the result register.
// Reset: asynchronous, active low; sequencer idles with SCL and SDA released,
// phase length returns to 7, the output valid flag clears (result register is not reset).
`timescale 1ns / 1ps

module i2c_register_master (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [6:0] dev_addr,
    input  logic [7:0] reg_addr,
    input  logic [7:0] wr_data,
    input  logic [7:0] rd_len,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic [7:0] rd_data,
    output logic       rd_valid,
    output logic       rd_last,
    output logic       done_res,
    output logic [1:0] status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0]          phase_ticks_val_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accept;
    i2crm_pkg::result_t  step_result;
    i2crm_pkg::result_t  result_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    i2crm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .cmd         (cmd),
        .dev_addr    (dev_addr),
        .reg_addr    (reg_addr),
        .wr_data     (wr_data),
        .rd_len      (rd_len),
        .sda_in      (sda_in),
        .phase_ticks (phase_ticks_val_reg),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_val_reg <= i2crm_pkg::PHASE_TICKS_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                phase_ticks_val_reg <= cfg_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = result_reg.scl_out;
    assign sda_out   = result_reg.sda_out;
    assign busy_res  = result_reg.busy_res;
    assign rd_data   = result_reg.rd_data;
    assign rd_valid  = result_reg.rd_valid;
    assign rd_last   = result_reg.rd_last;
    assign done_res  = result_reg.done_res;
    assign status    = result_reg.status;

endmodule
